### design/sorrw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorrw_pkg
// Shared types, codes and constants of the second-order reflecting walk.
// ----------------------------------------------------------------------------
package sorrw_pkg;

	localparam int DefaultPoints = 64;
	localparam int QueueDepth    = 2;

	typedef enum logic [1:0] {
		CMD_RESET  = 2'd0,
		CMD_STEP   = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_TAKE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_SEC_LOW        = 3'd0,
		REG_SEC_HIGH       = 3'd1,
		REG_PRI_LIMIT      = 3'd2,
		REG_PRI_STEP_SCALE = 3'd3,
		REG_SEC_STEP_SCALE = 3'd4,
		REG_SECOND_ORDER   = 3'd5,
		REG_POINTS_IN_USE  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [5:0]         index;
		logic signed [31:0] operand;
		logic [21:0]        position;
	} in_item_t;

	typedef struct packed {
		logic signed [47:0] value;
		logic               status;
	} out_item_t;

	// classified work handed from front to back
	typedef struct packed {
		cmd_t               cmd;
		logic               bad;
		logic [5:0]         idx_a;
		logic [5:0]         idx_b;
		logic signed [31:0] operand;
		logic [16:0]        frac;
	} job_t;

	typedef struct packed {
		logic signed [31:0] sec_low;
		logic signed [31:0] sec_high;
		logic [30:0]        pri_limit;
		logic [30:0]        pri_step_scale;
		logic [30:0]        sec_step_scale;
		logic               second_order;
		logic [6:0]         points_in_use;
	} cfg_t;

	localparam logic signed [47:0] SumMax = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] SumMin = 48'sh8000_0000_0000;

endpackage
`default_nettype wire

### design/sorrw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorrw_front
// Accepts input transactions, range-checks them and queues classified jobs.
// ----------------------------------------------------------------------------
module sorrw_front #(
	parameter int POINTS = sorrw_pkg::DefaultPoints
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire sorrw_pkg::in_item_t in_data,
	input  wire logic [6:0]          points_in_use,
	output logic                     job_valid,
	input  wire logic                job_ready,
	output sorrw_pkg::job_t          job
);

	localparam int QD = sorrw_pkg::QueueDepth;
	localparam logic [6:0] NMax = 7'((POINTS < 64) ? POINTS : 64);

	sorrw_pkg::job_t fifo_q [QD];
	logic [$clog2(QD)-1:0] wr_ptr_q, rd_ptr_q;
	logic [$clog2(QD):0]   count_q;
	logic [6:0]            n;
	logic [6:0]            x1, x2;
	sorrw_pkg::job_t       cj;
	logic                  push, pop;

	always_comb begin
		n = points_in_use;
		if (n == 7'd0) n = 7'd1;
		if (n > NMax) n = NMax;
		x1 = {1'b0, in_data.position[21:16]};
		x2 = x1 + 7'd1;
		if (x2 >= n) x2 = 7'd0;
		cj.cmd     = sorrw_pkg::cmd_t'(in_data.cmd);
		cj.operand = in_data.operand;
		cj.frac    = {1'b0, in_data.position[15:0]};
		if (cj.cmd == sorrw_pkg::CMD_LOOKUP) begin
			cj.idx_a = x1[5:0];
			cj.idx_b = x2[5:0];
			cj.bad   = x1 >= n;
		end else begin
			cj.idx_a = in_data.index;
			cj.idx_b = in_data.index;
			cj.bad   = ({1'b0, in_data.index} >= n) && (cj.cmd != sorrw_pkg::CMD_TAKE);
		end
	end

	assign in_ready  = count_q != QD[$clog2(QD):0];
	assign job_valid = count_q != '0;
	assign job       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = job_valid && job_ready;

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + {{$clog2(QD){1'b0}}, push} - {{$clog2(QD){1'b0}}, pop};
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QD[$clog2(QD):0]) else $error("queue overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == QD[$clog2(QD):0] |-> !push) else $error("push into full queue");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1) else $error("count slip");
`endif

endmodule
`default_nettype wire

### design/sorrw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorrw_back
// Executes jobs: walk tables, iterative fold divider, interpolation, sum.
// ----------------------------------------------------------------------------
module sorrw_back #(
	parameter int POINTS = sorrw_pkg::DefaultPoints
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sorrw_pkg::cfg_t  cfg,
	input  wire logic             job_valid,
	output logic                  job_ready,
	input  wire sorrw_pkg::job_t  job,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output sorrw_pkg::out_item_t  out_data
);

	localparam int Depth = (POINTS > 64) ? 64 : POINTS;
	localparam int AW = $clog2(Depth);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_LOOK1, ST_LOOK2, ST_MUL, ST_ADD,
		ST_FOLD_HI, ST_FOLD_LO, ST_DIV, ST_FIX, ST_WRITE, ST_OUT
	} state_t;

	state_t state_q;
	sorrw_pkg::job_t job_q;

	logic signed [31:0] pri_mem [Depth];
	logic signed [31:0] sec_mem [Depth];
	logic [Depth-1:0]   pvalid_q, svalid_q;
	logic signed [31:0] pri_rd_q, sec_rd_q, sec_rd2_q;
	logic [AW-1:0]      ra, rb;
	logic               stage2_q;

	logic signed [63:0] v_q;
	logic signed [63:0] lo_q, hi_q;
	logic [63:0]        span_q, rem_q, quo_q;
	logic [5:0]         bit_q;
	logic               above_q;
	logic signed [31:0] new_pri_q;
	logic signed [47:0] sum_q;
	sorrw_pkg::out_item_t out_q;
	logic               out_v_q;

	logic signed [63:0] prod;
	logic [30:0]        scale;
	logic signed [63:0] scaled;
	logic [64:0]        trial;
	logic signed [49:0] sum_n;
	logic signed [63:0] interp;

	assign ra = job_q.idx_a[AW-1:0];
	assign rb = job_q.idx_b[AW-1:0];

	always_comb begin
		scale  = (cfg.second_order) ? cfg.pri_step_scale : cfg.sec_step_scale;
		prod   = 64'(job_q.operand) * $signed({33'd0, scale});
		scaled = prod >>> 16;
		trial  = {rem_q, quo_q[63]} - {1'b0, span_q};
		sum_n  = 50'(sum_q) + 50'($signed(v_q[31:0]));
		interp = 64'(sec_rd_q) * $signed({47'd0, 17'd65536 - job_q.frac})
		       + 64'(sec_rd2_q) * $signed({47'd0, job_q.frac});
	end

	assign job_ready = (state_q == ST_IDLE) && !out_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			pri_rd_q  <= pvalid_q[ra] ? pri_mem[ra] : 32'sd0;
			sec_rd_q  <= svalid_q[ra] ? sec_mem[ra] : 32'sd0;
		end
		if (state_q == ST_LOOK1)
			sec_rd2_q <= svalid_q[rb] ? sec_mem[rb] : 32'sd0;
		if (state_q == ST_WRITE && job_q.cmd == sorrw_pkg::CMD_RESET) begin
			pri_mem[ra] <= 32'sd0;
			sec_mem[ra] <= job_q.operand;
		end else if (state_q == ST_WRITE) begin
			if (!stage2_q) pri_mem[ra] <= new_pri_q;
			else sec_mem[ra] <= v_q[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			out_v_q  <= 1'b0;
			pvalid_q <= '0;
			svalid_q <= '0;
			sum_q    <= '0;
			stage2_q <= 1'b0;
		end else begin
			if (out_v_q && out_ready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (job_valid && !out_v_q) begin
					job_q   <= job;
					state_q <= ST_RD;
				end
				ST_RD: begin
					priority if (job_q.bad) begin
						out_q.value  <= '0;
						out_q.status <= 1'b1;
						state_q      <= ST_OUT;
					end else if (job_q.cmd == sorrw_pkg::CMD_TAKE) begin
						out_q.value  <= sum_q;
						out_q.status <= 1'b0;
						sum_q        <= '0;
						state_q      <= ST_OUT;
					end else if (job_q.cmd == sorrw_pkg::CMD_RESET) begin
						out_q.value  <= 48'(job_q.operand);
						out_q.status <= 1'b0;
						state_q      <= ST_WRITE;
					end else if (job_q.cmd == sorrw_pkg::CMD_LOOKUP) begin
						state_q <= ST_LOOK1;
					end else begin
						stage2_q <= !cfg.second_order;
						state_q  <= ST_MUL;
					end
				end
				ST_LOOK1: state_q <= ST_LOOK2;
				ST_LOOK2: begin
					out_q.value  <= 48'(interp >>> 16);
					out_q.status <= 1'b0;
					state_q      <= ST_OUT;
				end
				ST_MUL: begin
					if (!stage2_q) begin
						v_q  <= 64'(pri_rd_q) + scaled;
						lo_q <= -$signed({33'd0, cfg.pri_limit});
						hi_q <= $signed({33'd0, cfg.pri_limit});
					end else begin
						v_q  <= 64'(sec_rd_q) +
							(cfg.second_order ? 64'(new_pri_q) : scaled);
						lo_q <= 64'(cfg.sec_low);
						hi_q <= 64'(cfg.sec_high);
					end
					state_q <= ST_FOLD_HI;
				end
				ST_FOLD_HI: begin
					span_q <= 64'(hi_q - lo_q);
					rem_q  <= '0;
					bit_q  <= 6'd63;
					if (hi_q <= lo_q) begin
						v_q     <= lo_q;
						state_q <= ST_ADD;
					end else if (v_q > hi_q) begin
						above_q <= 1'b1;
						quo_q   <= 64'(v_q - hi_q);
						state_q <= ST_DIV;
					end else if (v_q < lo_q) begin
						above_q <= 1'b0;
						quo_q   <= 64'(lo_q - v_q);
						state_q <= ST_DIV;
					end else state_q <= ST_ADD;
				end
				ST_DIV: begin
					if (!trial[64]) begin
						rem_q <= trial[63:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= {rem_q[62:0], quo_q[63]};
						quo_q <= {quo_q[62:0], 1'b0};
					end
					bit_q <= bit_q - 6'd1;
					if (bit_q == 6'd0) state_q <= ST_FIX;
				end
				ST_FIX: begin
					if (above_q)
						v_q <= quo_q[0] ? lo_q + $signed(rem_q) : hi_q - $signed(rem_q);
					else
						v_q <= quo_q[0] ? hi_q - $signed(rem_q) : lo_q + $signed(rem_q);
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (!stage2_q) new_pri_q <= v_q[31:0];
					state_q <= ST_WRITE;
				end
				ST_FOLD_LO: state_q <= ST_IDLE;
				ST_WRITE: begin
					if (job_q.cmd == sorrw_pkg::CMD_RESET) begin
						pvalid_q[ra] <= 1'b1;
						svalid_q[ra] <= 1'b1;
						state_q      <= ST_OUT;
					end else if (!stage2_q) begin
						pvalid_q[ra] <= 1'b1;
						stage2_q     <= 1'b1;
						state_q      <= ST_MUL;
					end else begin
						svalid_q[ra] <= 1'b1;
						if (sum_n > 50'(sorrw_pkg::SumMax)) sum_q <= sorrw_pkg::SumMax;
						else if (sum_n < 50'(sorrw_pkg::SumMin)) sum_q <= sorrw_pkg::SumMin;
						else sum_q <= sum_n[47:0];
						out_q.value  <= 48'($signed(v_q[31:0]));
						out_q.status <= 1'b0;
						state_q      <= ST_OUT;
					end
				end
				ST_OUT: begin
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ready |=> out_v_q && $stable(out_q)) else $error("result dropped");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && bit_q != 6'd0 |=> state_q == ST_DIV) else $error("divide cut short");
	a_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD && !job_q.bad && job_q.cmd == sorrw_pkg::CMD_TAKE |=> sum_q == '0)
		else $error("sum not cleared");
`endif

endmodule
`default_nettype wire

### design/second_order_reflecting_random_walk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// second_order_reflecting_random_walk
// Per-breakpoint second-order random walk with mirrored barriers.
// ----------------------------------------------------------------------------
// Input transactions (in_valid/in_ready) carry cmd, index, operand, position;
// each yields exactly one result transaction (out_valid/out_ready) with value
// and status. A front stage range-checks commands into a two-entry queue; the
// back end executes them one at a time. A fold runs a radix-2 divider of 64
// iterations; a first-order step can fold once, a second-order step once in
// each of its two walks. The back end takes the next job on the edge after a
// result is accepted, so it never starts a job before the last result is
// taken. Configuration writes (cfg_we/cfg_idx/cfg_data) are registered; the
// user must make them only while idle, and the block does not enforce it.
// arst_n restores register defaults, clears the walk tables through
// per-entry valid bits and zeros the period sum. A stalled receiver holds
// the result and pauses the back end; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module second_order_reflecting_random_walk #(
	parameter int POINTS = sorrw_pkg::DefaultPoints
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [2:0]           cfg_idx,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire sorrw_pkg::in_item_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output sorrw_pkg::out_item_t      out_data
);

	sorrw_pkg::cfg_t cfg_q;
	sorrw_pkg::job_t job;
	logic            job_valid, job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sec_low        <= -32'sd65536;
			cfg_q.sec_high       <= 32'sd65536;
			cfg_q.pri_limit      <= 31'd65536;
			cfg_q.pri_step_scale <= 31'd6554;
			cfg_q.sec_step_scale <= 31'd6554;
			cfg_q.second_order   <= 1'b1;
			cfg_q.points_in_use  <= 7'd64;
		end else if (cfg_we) begin
			unique case (sorrw_pkg::reg_idx_t'(cfg_idx))
				sorrw_pkg::REG_SEC_LOW:        cfg_q.sec_low        <= cfg_data;
				sorrw_pkg::REG_SEC_HIGH:       cfg_q.sec_high       <= cfg_data;
				sorrw_pkg::REG_PRI_LIMIT:      cfg_q.pri_limit      <= cfg_data[30:0];
				sorrw_pkg::REG_PRI_STEP_SCALE: cfg_q.pri_step_scale <= cfg_data[30:0];
				sorrw_pkg::REG_SEC_STEP_SCALE: cfg_q.sec_step_scale <= cfg_data[30:0];
				sorrw_pkg::REG_SECOND_ORDER:   cfg_q.second_order   <= cfg_data[0];
				sorrw_pkg::REG_POINTS_IN_USE:  cfg_q.points_in_use  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	sorrw_front #(.POINTS(POINTS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.points_in_use(cfg_q.points_in_use),
		.job_valid, .job_ready, .job
	);

	sorrw_back #(.POINTS(POINTS)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .job_valid, .job_ready, .job,
		.out_valid, .out_ready, .out_data
	);

endmodule
`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the second-order reflecting random walk. Drives
// command transactions with random idling, predicts each result in a
// scoreboard class, compares results field by field and runs several
// register settings.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS = 64;
	localparam longint SUM_HI = 64'sd140737488355327;
	localparam longint SUM_LO = -64'sd140737488355328;
	localparam longint LIMIT_CYCLES = 2000000;

	class walk_scoreboard;
		longint lo_bar, hi_bar, p_lim, p_scale, s_scale, order2, n_pts;
		longint pri[NPTS];
		longint sec[NPTS];
		longint psum;
		sorrw_pkg::out_item_t pending[$];
		int errors;

		function void clear_state();
			lo_bar = -65536; hi_bar = 65536; p_lim = 65536;
			p_scale = 6554; s_scale = 6554; order2 = 1; n_pts = 64;
			foreach (pri[i]) begin
				pri[i] = 0;
				sec[i] = 0;
			end
			psum = 0;
			errors = 0;
		endfunction

		function void write_reg(sorrw_pkg::reg_idx_t r, logic [31:0] d);
			case (r)
				sorrw_pkg::REG_SEC_LOW:        lo_bar = longint'(signed'(d));
				sorrw_pkg::REG_SEC_HIGH:       hi_bar = longint'(signed'(d));
				sorrw_pkg::REG_PRI_LIMIT:      p_lim = d[30:0];
				sorrw_pkg::REG_PRI_STEP_SCALE: p_scale = d[30:0];
				sorrw_pkg::REG_SEC_STEP_SCALE: s_scale = d[30:0];
				sorrw_pkg::REG_SECOND_ORDER:   order2 = d[0];
				sorrw_pkg::REG_POINTS_IN_USE:  n_pts = d[6:0];
				default: ;
			endcase
		endfunction

		function longint floor16(longint v);
			return v >>> 16;
		endfunction

		function longint mirror(longint v, longint lo, longint hi);
			longint span, d, q, r;
			if (hi <= lo) return lo;
			span = hi - lo;
			if (v > hi) begin
				d = v - hi; q = d / span; r = d % span;
				v = q[0] ? lo + r : hi - r;
			end
			if (v < lo) begin
				d = lo - v; q = d / span; r = d % span;
				v = q[0] ? hi - r : lo + r;
			end
			return v;
		endfunction

		function void note_input(sorrw_pkg::in_item_t it);
			longint n, res, opnd, p, s, x1, x2, f;
			sorrw_pkg::out_item_t e;
			n = (n_pts < 1) ? 1 : (n_pts > NPTS ? NPTS : n_pts);
			opnd = longint'(it.operand);
			res = 0;
			e.status = 1'b0;
			case (sorrw_pkg::cmd_t'(it.cmd))
				sorrw_pkg::CMD_RESET, sorrw_pkg::CMD_STEP: begin
					if (it.index >= n) e.status = 1'b1;
					else if (sorrw_pkg::cmd_t'(it.cmd) == sorrw_pkg::CMD_RESET) begin
						pri[it.index] = 0;
						sec[it.index] = opnd;
						res = opnd;
					end else begin
						if (order2 != 0) begin
							p = mirror(pri[it.index] + floor16(opnd * p_scale), -p_lim, p_lim);
							pri[it.index] = p;
							s = mirror(sec[it.index] + p, lo_bar, hi_bar);
						end else
							s = mirror(sec[it.index] + floor16(opnd * s_scale), lo_bar, hi_bar);
						sec[it.index] = s;
						psum += s;
						if (psum > SUM_HI) psum = SUM_HI;
						if (psum < SUM_LO) psum = SUM_LO;
						res = s;
					end
				end
				sorrw_pkg::CMD_LOOKUP: begin
					x1 = it.position[21:16];
					f = it.position[15:0];
					if (x1 >= n) e.status = 1'b1;
					else begin
						x2 = (x1 + 1 >= n) ? 0 : x1 + 1;
						res = floor16(sec[x1] * (65536 - f) + sec[x2] * f);
					end
				end
				default: begin
					res = psum;
					psum = 0;
				end
			endcase
			e.value = res[47:0];
			pending.push_back(e);
		endfunction

		function void check_result(sorrw_pkg::out_item_t got);
			sorrw_pkg::out_item_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result value=%0d status=%0b", $time,
					got.value, got.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.value !== e.value) begin
				$display("%0t value mismatch expected=%0d actual=%0d", $time,
					e.value, got.value);
				errors++;
			end
			if (got.status !== e.status) begin
				$display("%0t status mismatch expected=%0b actual=%0b", $time,
					e.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, cfg_we, in_valid, in_ready, out_valid, out_ready;
	logic [2:0] cfg_idx;
	logic [31:0] cfg_data;
	sorrw_pkg::in_item_t in_data;
	sorrw_pkg::out_item_t out_data;
	walk_scoreboard walk_sb;
	bit calm;
	longint cycles;

	second_order_reflecting_random_walk u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) walk_sb.check_result(out_data);
		if (arst_n && in_valid && in_ready) walk_sb.note_input(in_data);
	end

	always @(negedge clk) begin
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
	end

	task automatic write_cfg(sorrw_pkg::reg_idx_t r, logic [31:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= r;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		walk_sb.write_reg(r, d);
	endtask

	task automatic send(sorrw_pkg::cmd_t c, logic [5:0] ix, logic [31:0] op,
			logic [21:0] pos);
		if (!calm && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			do @(negedge clk); while (!calm && $urandom_range(99) < 22);
		end
		in_valid <= 1'b1;
		in_data <= '{cmd: c, index: ix, operand: op, position: pos};
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (walk_sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic random_item(int well_formed);
		sorrw_pkg::cmd_t c;
		logic [5:0] ix;
		logic [31:0] op;
		int sel;
		sel = $urandom_range(99);
		c = sel < 60 ? sorrw_pkg::CMD_STEP : sel < 72 ? sorrw_pkg::CMD_RESET :
			sel < 92 ? sorrw_pkg::CMD_LOOKUP : sorrw_pkg::CMD_TAKE;
		ix = well_formed ? $urandom_range(walk_sb.n_pts - 1) : $urandom;
		op = $urandom_range(3) == 0 ? $urandom : $urandom_range(262143) - 131072;
		send(c, ix, op, $urandom_range(3) == 0 ? $urandom :
			$urandom_range(walk_sb.n_pts * 65536 - 1));
	endtask

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) random_item($urandom_range(9) < 8);
		drain();
	endtask

	initial begin
		walk_sb = new();
		walk_sb.clear_state();
		calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
		in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(sorrw_pkg::CMD_LOOKUP, 0, 0, 0);
		send(sorrw_pkg::CMD_RESET, 0, 32'h7FFF_FFFF, 0);
		send(sorrw_pkg::CMD_RESET, 63, 32'h8000_0000, 0);
		send(sorrw_pkg::CMD_LOOKUP, 0, 0, 22'h3F_FFFF);
		send(sorrw_pkg::CMD_LOOKUP, 0, 0, 22'h00_8000);
		send(sorrw_pkg::CMD_STEP, 0, 32'h7FFF_FFFF, 0);
		send(sorrw_pkg::CMD_STEP, 63, 32'h8000_0000, 0);
		send(sorrw_pkg::CMD_STEP, 5, 32'h0001_0000, 0);
		send(sorrw_pkg::CMD_TAKE, 0, 0, 0);
		send(sorrw_pkg::CMD_TAKE, 0, 0, 0);
		drain();

		write_cfg(sorrw_pkg::REG_POINTS_IN_USE, 3);
		write_cfg(sorrw_pkg::REG_SECOND_ORDER, 0);
		write_cfg(sorrw_pkg::REG_SEC_STEP_SCALE, 32'h7FFF_FFFF);
		send(sorrw_pkg::CMD_STEP, 3, 5, 0);
		send(sorrw_pkg::CMD_RESET, 2, 32'h0003_0000, 0);
		send(sorrw_pkg::CMD_LOOKUP, 0, 0, 22'h02_4000);
		send(sorrw_pkg::CMD_LOOKUP, 0, 0, 22'h03_0000);
		send(sorrw_pkg::CMD_STEP, 1, 32'h7FFF_FFFF, 0);
		drain();
		write_cfg(sorrw_pkg::REG_SEC_LOW, 32'h0001_0000);
		write_cfg(sorrw_pkg::REG_SEC_HIGH, 32'h0001_0000);
		send(sorrw_pkg::CMD_STEP, 1, 32'h1234_5678, 0);
		drain();
		write_cfg(sorrw_pkg::REG_SEC_HIGH, 32'h0000_0000);
		send(sorrw_pkg::CMD_STEP, 0, 32'h1234_5678, 0);
		drain();

		write_cfg(sorrw_pkg::REG_POINTS_IN_USE, 0);
		write_cfg(sorrw_pkg::REG_SECOND_ORDER, 1);
		write_cfg(sorrw_pkg::REG_PRI_LIMIT, 0);
		write_cfg(sorrw_pkg::REG_PRI_STEP_SCALE, 32'h7FFF_FFFF);
		write_cfg(sorrw_pkg::REG_SEC_LOW, 32'h8000_0000);
		write_cfg(sorrw_pkg::REG_SEC_HIGH, 32'h7FFF_FFFF);
		random_phase(60);

		write_cfg(sorrw_pkg::REG_POINTS_IN_USE, 127);
		write_cfg(sorrw_pkg::REG_PRI_LIMIT, 32'h7FFF_FFFF);
		random_phase(120);

		write_cfg(sorrw_pkg::REG_POINTS_IN_USE, 64);
		write_cfg(sorrw_pkg::REG_PRI_LIMIT, 32'h0002_0000);
		write_cfg(sorrw_pkg::REG_PRI_STEP_SCALE, 6554);
		write_cfg(sorrw_pkg::REG_SEC_LOW, 32'hFFFF_0000);
		write_cfg(sorrw_pkg::REG_SEC_HIGH, 32'h0001_0000);
		calm = 1'b1;
		random_phase(150);
		calm = 1'b0;
		random_phase(200);

		write_cfg(sorrw_pkg::REG_POINTS_IN_USE, 1);
		write_cfg(sorrw_pkg::REG_SECOND_ORDER, 0);
		write_cfg(sorrw_pkg::REG_SEC_STEP_SCALE, 0);
		random_phase(60);

		write_cfg(sorrw_pkg::REG_POINTS_IN_USE, 17);
		write_cfg(sorrw_pkg::REG_SEC_STEP_SCALE, 32'h0004_0000);
		write_cfg(sorrw_pkg::REG_SEC_LOW, $urandom);
		write_cfg(sorrw_pkg::REG_SEC_HIGH, $urandom);
		random_phase(150);

		write_cfg(sorrw_pkg::REG_POINTS_IN_USE, 64);
		write_cfg(sorrw_pkg::REG_SECOND_ORDER, 1);
		write_cfg(sorrw_pkg::REG_SEC_LOW, 32'h8000_0000);
		write_cfg(sorrw_pkg::REG_SEC_HIGH, 32'h7FFF_FFFF);
		write_cfg(sorrw_pkg::REG_PRI_LIMIT, 32'h4000_0000);
		write_cfg(sorrw_pkg::REG_PRI_STEP_SCALE, 32'h0100_0000);
		random_phase(150);

		if (walk_sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
